// ===== rtl/i2cmra_pkg.sv =====
package i2cmra_pkg;

   // Bits in one byte on the wire.
   localparam int BYTE_BITS = 8;

   // Item kinds carried on the request side.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // Transaction status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BUS_BUSY  = 2'd1;
   localparam logic [1:0] STATUS_ADDR_NACK = 2'd2;
   localparam logic [1:0] STATUS_ZERO_LEN  = 2'd3;

   // Bus segments; each one runs through up to four sub-steps.
   typedef enum logic [3:0] {
      SEG_IDLE    = 4'd0,
      SEG_ST      = 4'd1,
      SEG_SD_DEV  = 4'd2,
      SEG_WA_DEV  = 4'd3,
      SEG_SD_REG  = 4'd4,
      SEG_WA_REG  = 4'd5,
      SEG_SD_DATA = 4'd6,
      SEG_WA_DATA = 4'd7,
      SEG_RS      = 4'd8,
      SEG_SD_DEVR = 4'd9,
      SEG_WA_DEVR = 4'd10,
      SEG_RD      = 4'd11,
      SEG_MA      = 4'd12,
      SEG_SP      = 4'd13
   } seg_type;

   typedef enum logic [1:0] {
      BIT_KEEP,
      BIT_CLR,
      BIT_INC,
      BIT_ACK
   } bit_op_type;

   typedef enum logic [2:0] {
      LOAD_NONE,
      LOAD_DEV,
      LOAD_DEV_INC,
      LOAD_REG,
      LOAD_ZERO,
      LOAD_STORE
   } load_type;

   // Per-tick control decoded from the current bus segment and step.
   typedef struct packed {
      logic       scl_we;
      logic       scl_val;
      logic       sda_we;
      logic       sda_val;
      bit_op_type bit_op;
      load_type   load;
      logic       shift_out;
      logic       shift_in;
      logic       rx_done;
      logic       take_inc;
      logic       byte_dec;
      logic       finish;
      logic       status_we;
      logic [1:0] status_val;
   } ctl_type;

endpackage

// ===== rtl/i2c_master_register_access.sv =====
// I2C master that runs register write and read transactions, one bus step per tick.
// Request channel: req_tuser carries the item kind (tick, queue a write byte, or
// start a transaction); req_tdata carries the sampled SDA level and the start and
// write-byte arguments. A start latches device and register address, direction
// and byte count; ticks then walk the start, address, data, ack and stop phases.
// Response channel: every accepted request transfer yields exactly one response
// transfer with the line drives, busy flag, received byte and status after that
// item; rsp_tuser flags a freshly received byte and rsp_tlast marks the item on
// which a transaction ends.
// A valid response appears in the cycle after request acceptance, and one item
// is taken per cycle while no response waits; all state updates fit between the
// input handshake and the response register, and the write byte queue is read
// through a registered RAM whose address is set well before the byte is needed.
// Reset returns the sequencer to idle with both lines released, empties the queue
// and clears the status; the queue RAM needs no clearing pass.
// When the receiver stalls, the response register holds its transfer and
// req_tready stays low until the waiting response is taken.
module i2c_master_register_access #(
   parameter int WRITE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] sda_in, [1] is_read, [9:2] device_address, [17:10] register_address,
   // [22:18] byte_count, [30:23] data_byte, [31] zero
   input  logic [31:0] req_tdata,
   // [1:0] op
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] scl_out, [1] sda_out, [2] busy_res, [10:3] rx_byte, [12:11] status,
   // [15:13] zero
   output logic [15:0] rsp_tdata,
   // [0] rx_valid
   output logic        rsp_tuser,
   // done_res
   output logic        rsp_tlast
);

   import i2cmra_pkg::*;

   localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
   localparam int CW = $clog2(WRITE_DEPTH + 1);

   // Request fields.
   logic [1:0] op;
   logic       sda_in;
   logic       is_read;
   logic [7:0] device_address;
   logic [7:0] register_address;
   logic [4:0] byte_count;
   logic [7:0] data_byte;

   assign op               = req_tuser;
   assign sda_in           = req_tdata[0];
   assign is_read          = req_tdata[1];
   assign device_address   = req_tdata[9:2];
   assign register_address = req_tdata[17:10];
   assign byte_count       = req_tdata[22:18];
   assign data_byte        = req_tdata[30:23];

   // Sequencer and datapath state.
   seg_type       seg_ff, seg_in;
   logic [1:0]    st_ff, st_in;
   logic [3:0]    bit_counter_ff, bit_counter_in;
   logic [4:0]    bytes_left_ff, bytes_left_in;
   logic [7:0]    shift_ff, shift_in;
   logic [CW-1:0] write_fill_ff, write_fill_in;
   logic [CW-1:0] write_take_ff, write_take_in;
   logic [7:0]    latched_dev_ff, latched_dev_in;
   logic [7:0]    latched_reg_ff, latched_reg_in;
   logic          read_flag_ff, read_flag_in;
   logic [1:0]    status_ff, status_in;
   logic          scl_ff, scl_in;
   logic          sda_ff, sda_in_drv;

   // Bypass for a queue write that lands on the address being read.
   logic          byp_valid_ff, byp_valid_in;
   logic [7:0]    byp_data_ff;

   // Response register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_data_ff;
   logic          rsp_user_ff;
   logic          rsp_last_ff;

   logic          accept;
   logic          tick;
   logic          start;
   logic          start_zero;
   logic [4:0]    cnt;
   logic          bus_fail;
   logic [3:0]    bc_next;
   logic          bc_full;
   logic          queue_wr;
   logic [7:0]    ram_q;
   logic [7:0]    store_val;
   logic [7:0]    rx_shift;
   ctl_type       ctl;
   logic          finish_any;
   logic          finish_read;
   logic          done;

   // A new request is taken whenever the response register is empty or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign tick  = accept && (op == OP_TICK) && (seg_ff != SEG_IDLE);
   assign start = accept && (op == OP_START) && (seg_ff == SEG_IDLE);

   // A write transaction never sends more bytes than the queue can hold.
   assign cnt = (!is_read && (int'(byte_count) > WRITE_DEPTH)) ?
                5'(WRITE_DEPTH) : byte_count;
   assign start_zero = start && (cnt == 5'd0);

   // The bus must read high before the master pulls SDA, and low after.
   assign bus_fail = tick && (seg_ff == SEG_ST) &&
                     (((st_ff == 2'd0) && !sda_in) || ((st_ff == 2'd1) && sda_in));

   assign bc_next  = bit_counter_ff + 4'd1;
   assign bc_full  = bc_next >= 4'(BYTE_BITS);
   assign rx_shift = {shift_ff[6:0], sda_in};

   // Write byte queue.
   assign queue_wr = accept && (op == OP_WRITE) && (write_fill_ff < CW'(WRITE_DEPTH));

   i2cmra_ram #(
      .WIDTH (8),
      .DEPTH (WRITE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (queue_wr),
      .wr_addr (write_fill_ff[AW-1:0]),
      .wr_data (data_byte),
      .rd_addr (write_take_ff[AW-1:0]),
      .rd_data (ram_q)
   );

   assign byp_valid_in = queue_wr && (write_fill_ff == write_take_ff);

   // A byte past the queued ones goes out as zero.
   assign store_val = ((write_take_ff < write_fill_ff) &&
                       (write_take_ff < CW'(WRITE_DEPTH))) ?
                      (byp_valid_ff ? byp_data_ff : ram_q) : 8'h00;

   // Next bus segment and step.
   always_comb begin
      seg_in = seg_ff;
      st_in  = st_ff;
      if (start) begin
         seg_in = (cnt == 5'd0) ? SEG_IDLE : SEG_ST;
         st_in  = 2'd0;
      end else if (tick) begin
         case (seg_ff)
            SEG_ST, SEG_RS: begin
               if (bus_fail) begin
                  seg_in = SEG_IDLE;
                  st_in  = 2'd0;
               end else if (st_ff == 2'd0 || st_ff == 2'd1) begin
                  st_in = st_ff + 2'd1;
               end else begin
                  seg_in = (seg_ff == SEG_ST) ? SEG_SD_DEV : SEG_SD_DEVR;
                  st_in  = 2'd0;
               end
            end
            SEG_SD_DEV, SEG_SD_REG, SEG_SD_DATA, SEG_SD_DEVR: begin
               if (st_ff == 2'd0 || st_ff == 2'd1) begin
                  st_in = st_ff + 2'd1;
               end else begin
                  st_in = 2'd0;
                  if (bc_full) begin
                     seg_in = seg_type'(4'(seg_ff) + 4'd1);
                  end
               end
            end
            SEG_WA_DEV, SEG_WA_REG, SEG_WA_DATA, SEG_WA_DEVR: begin
               if (st_ff != 2'd3) begin
                  st_in = st_ff + 2'd1;
               end else begin
                  st_in = 2'd0;
                  if (seg_ff == SEG_WA_DEV) begin
                     seg_in = (bit_counter_ff != 4'd0) ? SEG_SP : SEG_SD_REG;
                  end else if (seg_ff == SEG_WA_REG && read_flag_ff) begin
                     seg_in = SEG_RS;
                  end else if (seg_ff == SEG_WA_DEVR) begin
                     seg_in = SEG_RD;
                  end else if (bytes_left_ff == 5'd0) begin
                     seg_in = SEG_SP;
                  end else begin
                     seg_in = SEG_SD_DATA;
                  end
               end
            end
            SEG_RD: begin
               if (st_ff == 2'd0) begin
                  st_in = 2'd1;
               end else begin
                  st_in  = 2'd0;
                  seg_in = bc_full ? SEG_MA : SEG_RD;
               end
            end
            SEG_MA: begin
               if (st_ff != 2'd3) begin
                  st_in = st_ff + 2'd1;
               end else begin
                  st_in  = 2'd0;
                  seg_in = (bytes_left_ff == 5'd0) ? SEG_SP : SEG_RD;
               end
            end
            SEG_SP: begin
               if (st_ff != 2'd3) begin
                  st_in = st_ff + 2'd1;
               end else begin
                  seg_in = SEG_IDLE;
                  st_in  = 2'd0;
               end
            end
            default: begin
               seg_in = SEG_IDLE;
               st_in  = 2'd0;
            end
         endcase
      end
   end

   // Line drives and datapath control for a tick in the current step.
   always_comb begin
      ctl = '0;
      if (tick) begin
         case (seg_ff)
            SEG_ST, SEG_RS: begin
               case (st_ff)
                  2'd0: begin
                     ctl.scl_we  = 1'b1;
                     ctl.scl_val = 1'b1;
                     ctl.sda_we  = 1'b1;
                     ctl.sda_val = 1'b1;
                  end
                  2'd1: begin
                     ctl.sda_we  = 1'b1;
                     ctl.sda_val = 1'b0;
                  end
                  default: begin
                     ctl.load   = (seg_ff == SEG_ST) ? LOAD_DEV : LOAD_DEV_INC;
                     ctl.bit_op = BIT_CLR;
                  end
               endcase
               if (bus_fail) begin
                  ctl.finish     = 1'b1;
                  ctl.status_we  = 1'b1;
                  ctl.status_val = STATUS_BUS_BUSY;
                  ctl.bit_op     = BIT_CLR;
               end
            end
            SEG_SD_DEV, SEG_SD_REG, SEG_SD_DATA, SEG_SD_DEVR: begin
               case (st_ff)
                  2'd0: begin
                     ctl.scl_we = 1'b1;
                  end
                  2'd1: begin
                     ctl.sda_we    = 1'b1;
                     ctl.sda_val   = shift_ff[7];
                     ctl.shift_out = 1'b1;
                  end
                  default: begin
                     ctl.scl_we  = 1'b1;
                     ctl.scl_val = 1'b1;
                     ctl.bit_op  = bc_full ? BIT_CLR : BIT_INC;
                  end
               endcase
            end
            SEG_WA_DEV, SEG_WA_REG, SEG_WA_DATA, SEG_WA_DEVR: begin
               case (st_ff)
                  2'd0: begin
                     ctl.scl_we = 1'b1;
                  end
                  2'd1: begin
                     ctl.sda_we  = 1'b1;
                     ctl.sda_val = 1'b1;
                  end
                  2'd2: begin
                     ctl.scl_we  = 1'b1;
                     ctl.scl_val = 1'b1;
                     ctl.bit_op  = BIT_ACK;
                  end
                  default: begin
                     ctl.scl_we = 1'b1;
                     ctl.bit_op = BIT_CLR;
                     if (seg_ff == SEG_WA_DEV) begin
                        if (bit_counter_ff != 4'd0) begin
                           ctl.status_we  = 1'b1;
                           ctl.status_val = STATUS_ADDR_NACK;
                        end else begin
                           ctl.load = LOAD_REG;
                        end
                     end else if (seg_ff == SEG_WA_REG && read_flag_ff) begin
                        ctl.load = LOAD_NONE;
                     end else if (seg_ff == SEG_WA_DEVR) begin
                        ctl.load = LOAD_ZERO;
                     end else if (bytes_left_ff != 5'd0) begin
                        ctl.load     = LOAD_STORE;
                        ctl.take_inc = 1'b1;
                        ctl.byte_dec = 1'b1;
                     end
                  end
               endcase
            end
            SEG_RD: begin
               if (st_ff == 2'd0) begin
                  ctl.scl_we  = 1'b1;
                  ctl.sda_we  = 1'b1;
                  ctl.sda_val = 1'b1;
               end else begin
                  ctl.scl_we   = 1'b1;
                  ctl.scl_val  = 1'b1;
                  ctl.shift_in = 1'b1;
                  ctl.bit_op   = bc_full ? BIT_CLR : BIT_INC;
                  ctl.rx_done  = bc_full;
                  ctl.byte_dec = bc_full;
               end
            end
            SEG_MA: begin
               case (st_ff)
                  2'd0: begin
                     ctl.scl_we = 1'b1;
                  end
                  2'd1: begin
                     // Ack every byte but the last one.
                     ctl.sda_we  = 1'b1;
                     ctl.sda_val = (bytes_left_ff == 5'd0);
                  end
                  2'd2: begin
                     ctl.scl_we  = 1'b1;
                     ctl.scl_val = 1'b1;
                  end
                  default: begin
                     ctl.scl_we = 1'b1;
                     ctl.bit_op = BIT_CLR;
                     if (bytes_left_ff != 5'd0) begin
                        ctl.load = LOAD_ZERO;
                     end
                  end
               endcase
            end
            SEG_SP: begin
               case (st_ff)
                  2'd0: begin
                     ctl.scl_we = 1'b1;
                  end
                  2'd1: begin
                     ctl.sda_we = 1'b1;
                  end
                  2'd2: begin
                     ctl.scl_we  = 1'b1;
                     ctl.scl_val = 1'b1;
                  end
                  default: begin
                     ctl.sda_we  = 1'b1;
                     ctl.sda_val = 1'b1;
                     ctl.finish  = 1'b1;
                     ctl.bit_op  = BIT_CLR;
                  end
               endcase
            end
            default: begin
               ctl = '0;
            end
         endcase
      end
   end

   // A finished write transaction releases the queue; a rejected write start counts too.
   assign finish_any  = ctl.finish || start_zero;
   assign finish_read = start_zero ? is_read : read_flag_ff;
   assign done        = finish_any;

   // Datapath next values.
   always_comb begin
      scl_in         = ctl.scl_we ? ctl.scl_val : scl_ff;
      sda_in_drv     = ctl.sda_we ? ctl.sda_val : sda_ff;
      shift_in       = shift_ff;
      bit_counter_in = bit_counter_ff;
      bytes_left_in  = bytes_left_ff;
      status_in      = status_ff;
      latched_dev_in = latched_dev_ff;
      latched_reg_in = latched_reg_ff;
      read_flag_in   = read_flag_ff;
      write_fill_in  = write_fill_ff;
      write_take_in  = write_take_ff;

      case (ctl.load)
         LOAD_DEV:     shift_in = latched_dev_ff;
         LOAD_DEV_INC: shift_in = latched_dev_ff + 8'd1;
         LOAD_REG:     shift_in = latched_reg_ff;
         LOAD_ZERO:    shift_in = 8'h00;
         LOAD_STORE:   shift_in = store_val;
         default: begin
            if (ctl.shift_out) begin
               shift_in = {shift_ff[6:0], 1'b0};
            end else if (ctl.shift_in) begin
               shift_in = rx_shift;
            end
         end
      endcase

      case (ctl.bit_op)
         BIT_CLR: bit_counter_in = 4'd0;
         BIT_INC: bit_counter_in = bc_next;
         BIT_ACK: bit_counter_in = {3'b000, sda_in};
         default: bit_counter_in = bit_counter_ff;
      endcase

      if (ctl.byte_dec) begin
         bytes_left_in = bytes_left_ff - 5'd1;
      end
      if (ctl.status_we) begin
         status_in = ctl.status_val;
      end
      if (ctl.take_inc) begin
         write_take_in = write_take_ff + CW'(1);
      end
      if (queue_wr) begin
         write_fill_in = write_fill_ff + CW'(1);
      end

      if (start) begin
         latched_dev_in = device_address;
         latched_reg_in = register_address;
         read_flag_in   = is_read;
         bytes_left_in  = cnt;
         bit_counter_in = 4'd0;
         status_in      = (cnt == 5'd0) ? STATUS_ZERO_LEN : STATUS_OK;
         if (cnt != 5'd0) begin
            write_take_in = '0;
         end
      end

      if (finish_any && !finish_read) begin
         write_fill_in = '0;
         write_take_in = '0;
      end
   end

   // The response register is loaded on every accepted request.
   assign rsp_valid_in = accept ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff         <= SEG_IDLE;
         st_ff          <= 2'd0;
         bit_counter_ff <= 4'd0;
         bytes_left_ff  <= 5'd0;
         shift_ff       <= 8'h00;
         write_fill_ff  <= '0;
         write_take_ff  <= '0;
         latched_dev_ff <= 8'h00;
         latched_reg_ff <= 8'h00;
         read_flag_ff   <= 1'b0;
         status_ff      <= STATUS_OK;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         byp_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         seg_ff         <= seg_in;
         st_ff          <= st_in;
         bit_counter_ff <= bit_counter_in;
         bytes_left_ff  <= bytes_left_in;
         shift_ff       <= shift_in;
         write_fill_ff  <= write_fill_in;
         write_take_ff  <= write_take_in;
         latched_dev_ff <= latched_dev_in;
         latched_reg_ff <= latched_reg_in;
         read_flag_ff   <= read_flag_in;
         status_ff      <= status_in;
         scl_ff         <= scl_in;
         sda_ff         <= sda_in_drv;
         byp_valid_ff   <= byp_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= data_byte;
      if (accept) begin
         rsp_data_ff <= {3'b000, status_in,
                         (ctl.rx_done ? rx_shift : 8'h00),
                         (seg_in != SEG_IDLE), sda_in_drv, scl_in};
         rsp_user_ff <= ctl.rx_done;
         rsp_last_ff <= done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // The queue never holds more bytes than it has room for.
   assert property (@(posedge clock) disable iff (reset)
      write_fill_ff <= CW'(WRITE_DEPTH))
      else $error("write queue fill count exceeds its depth");

   // A bit count of a full byte is never carried into the next step.
   assert property (@(posedge clock) disable iff (reset)
      bit_counter_ff < 4'(BYTE_BITS))
      else $error("bit counter left at a full byte");

   // The last stop step ends the transaction and reports idle.
   assert property (@(posedge clock) disable iff (reset)
      (tick && seg_ff == SEG_SP && st_ff == 2'd3) |=>
         (seg_ff == SEG_IDLE && rsp_tlast && !rsp_tdata[2]))
      else $error("stop did not end the transaction");

   // A start with a nonzero length enters the start phase with the queue rewound.
   assert property (@(posedge clock) disable iff (reset)
      (start && cnt != 5'd0) |=>
         (seg_ff == SEG_ST && st_ff == 2'd0 && write_take_ff == '0 && rsp_tdata[2]))
      else $error("start did not enter the start phase");
`endif

endmodule

// ===== rtl/i2cmra_ram.sv =====
module i2cmra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
